### hdl/packed_low_bit_weight_dot_product_assert.svh
`ifndef PACKED_LOW_BIT_WEIGHT_DOT_PRODUCT_ASSERT_SVH
`define PACKED_LOW_BIT_WEIGHT_DOT_PRODUCT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pldp assertion failed");

// next-cycle implication, checked outside reset
`define PLDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pldp assertion failed");

`endif

### hdl/pldp_pkg.sv
`timescale 1ns / 1ps
package pldp_pkg;

    localparam int LANES         = 8;
    localparam int TERNARY_LANES = 4;
    localparam int ACT_W         = 8;
    localparam int CODE_W        = 2;
    localparam int LANE_SUM_W    = 11;
    localparam int SUM_W         = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic MODE_TERNARY = 1'b0;
    localparam logic MODE_BINARY  = 1'b1;

    localparam logic [CODE_W-1:0] CODE_NEG  = 2'd0;
    localparam logic [CODE_W-1:0] CODE_ZERO = 2'd1;

    typedef enum logic [1:0] {
        SEL_NEG,
        SEL_ZERO,
        SEL_POS
    } sel_t;

    typedef struct packed {
        logic [LANES-1:0][ACT_W-1:0] act;
        sel_t [LANES-1:0]            sel;
        logic                        last;
    } item_t;

    // negating the most negative value wraps back to itself
    function automatic logic [ACT_W-1:0] lane_value(sel_t sel, logic [ACT_W-1:0] act);
        logic [ACT_W-1:0] v;
        case (sel)
            SEL_POS: v = act;
            SEL_NEG: v = ACT_W'(~act + 1'b1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hdl/pldp_front.sv
`timescale 1ns / 1ps
module pldp_front
    import pldp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 weight_mode,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           weight_byte,
    input  logic [LANES-1:0][ACT_W-1:0] acts,
    input  logic                 last_item,
    output logic                 push_valid,
    input  logic                 push_ready,
    output item_t                push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign in_ready = !valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [CODE_W-1:0] code;
        item_next.act  = acts;
        item_next.last = last_item;
        for (int k = 0; k < LANES; k++)
        begin
            code = weight_byte[(LANES-1) - 2*(k % TERNARY_LANES) -: CODE_W];
            if (weight_mode == MODE_BINARY)
            begin
                item_next.sel[k] = weight_byte[(LANES-1) - k] ? SEL_POS : SEL_NEG;
            end
            else if (k >= TERNARY_LANES)
            begin
                item_next.sel[k] = SEL_ZERO;
            end
            else
            begin
                case (code)
                    CODE_NEG:  item_next.sel[k] = SEL_NEG;
                    CODE_ZERO: item_next.sel[k] = SEL_ZERO;
                    default:   item_next.sel[k] = SEL_POS;
                endcase
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

### hdl/pldp_queue.sv
`timescale 1ns / 1ps
`include "packed_low_bit_weight_dot_product_assert.svh"
module pldp_queue
    import pldp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `PLDP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `PLDP_ASSERT_NOW(a_ptr_gap, count_reg == '0 || count_reg == CNT_W'(DEPTH), wr_ptr_reg == rd_ptr_reg)
    `PLDP_ASSERT_NEXT(a_push_only_grows, push && !pop, count_reg != '0)

endmodule

### hdl/pldp_back.sv
`timescale 1ns / 1ps
`include "packed_low_bit_weight_dot_product_assert.svh"
module pldp_back
    import pldp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  item_t            pop_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SUM_W-1:0] dot_sum
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [LANE_SUM_W-1:0] s1_sum_reg;
    logic [LANE_SUM_W-1:0] s1_sum_next;
    logic                  s1_last_reg;
    logic                  s1_adv;
    logic [SUM_W-1:0]      acc_reg;
    logic [SUM_W-1:0]      acc_next;
    logic [SUM_W-1:0]      total;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SUM_W-1:0]      out_data_reg;

    // eight sign-select lanes into one narrow sum
    always_comb
    begin
        logic [ACT_W-1:0] v;
        s1_sum_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            v = lane_value(pop_item.sel[k], pop_item.act[k]);
            s1_sum_next = LANE_SUM_W'(s1_sum_next
                + {{(LANE_SUM_W-ACT_W){v[ACT_W-1]}}, v});
        end
    end

    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign pop_ready = !s1_valid_reg || s1_adv;
    assign total     = acc_reg + {{(SUM_W-LANE_SUM_W){s1_sum_reg[LANE_SUM_W-1]}}, s1_sum_reg};

    always_comb
    begin
        s1_valid_next  = pop_ready ? pop_valid : s1_valid_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_adv)
        begin
            acc_next = s1_last_reg ? '0 : total;
            if (s1_last_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            s1_sum_reg  <= s1_sum_next;
            s1_last_reg <= pop_item.last;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_data_reg <= total;
        end
    end

    assign out_valid = out_valid_reg;
    assign dot_sum   = out_data_reg;

    `PLDP_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_reg, acc_reg == '0)
    `PLDP_ASSERT_NOW(a_no_overwrite, s1_adv && s1_last_reg, !out_valid_reg || out_ready)
    `PLDP_ASSERT_NEXT(a_stall_holds, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_sum_reg))

endmodule

### hdl/packed_low_bit_weight_dot_product.sv
`timescale 1ns / 1ps
// Dot product of packed ternary or binary weights with eight signed 8-bit activations per
// request. weight_mode (written via cfg_we/cfg_wdata while idle, a user rule the block does not
// enforce) picks four 2-bit codes or eight sign bits, MSB first. The 32-bit sum wraps and is sent
// out and cleared on the request with last_item set. One request per cycle is sustained unless a
// last request is held behind a waiting result. A last request passes the front register, queue,
// lane-sum and output registers. Non-last requests keep flowing while a result waits on out_ready.
module packed_low_bit_weight_dot_product
    import pldp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  weight_byte,
    input  logic signed [7:0] act_0,
    input  logic signed [7:0] act_1,
    input  logic signed [7:0] act_2,
    input  logic signed [7:0] act_3,
    input  logic signed [7:0] act_4,
    input  logic signed [7:0] act_5,
    input  logic signed [7:0] act_6,
    input  logic signed [7:0] act_7,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] dot_sum
);

    logic                        weight_mode_reg;
    logic [LANES-1:0][ACT_W-1:0] acts;
    logic                        push_valid;
    logic                        push_ready;
    item_t                       push_item;
    logic                        pop_valid;
    logic                        pop_ready;
    item_t                       pop_item;
    logic [SUM_W-1:0]            sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_mode_reg <= MODE_TERNARY;
        end
        else if (cfg_we)
        begin
            weight_mode_reg <= cfg_wdata;
        end
    end

    assign acts = {act_7, act_6, act_5, act_4, act_3, act_2, act_1, act_0};

    pldp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .weight_mode (weight_mode_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .weight_byte (weight_byte),
        .acts        (acts),
        .last_item   (last_item),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    pldp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pldp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dot_sum   (sum)
    );

    assign dot_sum = sum;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import pldp_pkg::*;

    localparam logic [7:0] ACT_MOST_NEG = 8'h80;
    localparam int         DRAIN_PAD    = 8;
    localparam int         MAX_GAP      = 11;
    localparam int         MAX_REPORTS  = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic [7:0] weight_byte;
    logic [7:0][7:0] acts_drv;
    logic last_item;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] dot_sum;

    // predictor state
    logic [31:0] running_total;
    logic        active_mode;
    logic [31:0] expected_sums [$];

    // side control
    bit in_quiet;
    bit out_quiet;
    int hold_cycles;

    int error_count;
    int mismatch_count;
    int request_count;
    int ternary_requests;
    int binary_requests;
    int sum_count;

    packed_low_bit_weight_dot_product dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .weight_byte(weight_byte),
        .act_0      (acts_drv[0]),
        .act_1      (acts_drv[1]),
        .act_2      (acts_drv[2]),
        .act_3      (acts_drv[3]),
        .act_4      (acts_drv[4]),
        .act_5      (acts_drv[5]),
        .act_6      (acts_drv[6]),
        .act_7      (acts_drv[7]),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dot_sum    (dot_sum)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] weighted_sum_of(input logic mode, input logic [7:0] wb,
                                                    input logic [7:0][7:0] acts);
        logic [31:0] total;
        logic signed [31:0] pass_v;
        logic signed [31:0] neg_v;
        logic [1:0] code;
        total = '0;
        for (int k = 0; k < 8; k++)
        begin
            pass_v = $signed(acts[k]);
            // minus 128 stays minus 128
            neg_v = (acts[k] == ACT_MOST_NEG) ? pass_v : -pass_v;
            if (mode == MODE_TERNARY)
            begin
                if (k < 4)
                begin
                    code = wb[7 - 2 * k -: 2];
                    if (code == CODE_NEG)
                        total += neg_v;
                    else if (code != CODE_ZERO)
                        total += pass_v;
                end
            end
            else
            begin
                total += wb[7 - k] ? pass_v : neg_v;
            end
        end
        return total;
    endfunction

    function automatic logic [7:0] draw_act();
        logic [7:0] a;
        case ($urandom_range(0, 7))
            0: a = ACT_MOST_NEG;
            1: a = 8'h7F;
            2: a = 8'h00;
            3: a = 8'hFF;
            default: a = 8'($urandom);
        endcase
        return a;
    endfunction

    function automatic logic [7:0] draw_weights();
        logic [7:0] w;
        case ($urandom_range(0, 9))
            0: w = 8'h00;
            1: w = 8'hFF;
            2: w = 8'h55;
            3: w = 8'hAA;
            default: w = 8'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_request(input logic [7:0] wb, input logic [7:0][7:0] acts,
                                input logic last);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            weight_byte = 8'($urandom);
            acts_drv = {$urandom, $urandom};
            last_item = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        weight_byte = wb;
        acts_drv = acts;
        last_item = last;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        running_total += weighted_sum_of(active_mode, wb, acts);
        request_count++;
        if (active_mode == MODE_TERNARY)
            ternary_requests++;
        else
            binary_requests++;
        if (last)
        begin
            expected_sums.push_back(running_total);
            running_total = '0;
        end
    endtask

    task automatic send_random(input logic last);
        logic [7:0][7:0] acts;
        for (int k = 0; k < 8; k++)
            acts[k] = draw_act();
        send_request(draw_weights(), acts, last);
    endtask

    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
            send_random(i == len - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic set_weight_mode(input logic mode);
        wait_drained();
        cfg_we = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        active_mode = mode;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
    endtask

    task automatic test_ternary_directed();
        set_weight_mode(MODE_TERNARY);
        send_request(8'b00_01_10_11, {8'h11, 8'h22, 8'h33, 8'h44, 8'h80, 8'h7F, 8'h80, 8'h7F},
                     1'b1);
        send_request(8'h00, {8{ACT_MOST_NEG}}, 1'b1);
        send_request(8'hFF, {8{8'h7F}}, 1'b0);
        send_request(8'hAA, {8{ACT_MOST_NEG}}, 1'b0);
        send_request(8'h55, {8{8'h7F}}, 1'b0);
        send_request(8'h00, {8{8'h7F}}, 1'b1);
        send_request(8'h1B, {8'h01, 8'h02, 8'h03, 8'h04, 8'hFF, 8'h00, 8'h80, 8'h81}, 1'b1);
        send_request(8'hE4, {8{8'h00}}, 1'b1);
    endtask

    task automatic test_binary_directed();
        set_weight_mode(MODE_BINARY);
        send_request(8'h00, {8{ACT_MOST_NEG}}, 1'b1);
        send_request(8'hFF, {8{8'h7F}}, 1'b1);
        send_request(8'hFF, {8{ACT_MOST_NEG}}, 1'b0);
        send_request(8'h00, {8{8'h7F}}, 1'b0);
        send_request(8'hA5, {8'h80, 8'h7F, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFF, 8'h01}, 1'b1);
        send_request(8'h5A, {8'h80, 8'h7F, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFF, 8'h01}, 1'b1);
        send_request(8'h81, {8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'h80}, 1'b1);
    endtask

    // partial sum carried across a change of weight format
    task automatic test_mode_switch_mid_vector();
        set_weight_mode(MODE_TERNARY);
        send_request(8'hC3, {8'h80, 8'h40, 8'hC0, 8'h7F, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b0);
        set_weight_mode(MODE_BINARY);
        send_request(8'h3C, {8'h80, 8'h40, 8'hC0, 8'h7F, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b1);
        set_weight_mode(MODE_TERNARY);
        send_random(1'b0);
        send_random(1'b0);
        send_random(1'b1);
    endtask

    task automatic test_random_vectors(input int target);
        int start_count;
        int len;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_weight_mode(phase[0] ? MODE_BINARY : MODE_TERNARY);
            start_count = request_count;
            while (request_count - start_count < target / 4)
            begin
                in_quiet = ($urandom_range(0, 5) == 0);
                out_quiet = ($urandom_range(0, 5) == 0);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
                send_vector(len);
            end
        end
        in_quiet = 1'b0;
        out_quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        set_weight_mode(MODE_BINARY);
        in_quiet = 1'b1;
        hold_cycles = 150;
        for (int i = 0; i < 30; i++)
            send_random(1'b1);
        for (int i = 0; i < 10; i++)
            send_random(i[0]);
        in_quiet = 1'b0;
        // sender waits for every sum before going on
        wait_drained();
        set_weight_mode(MODE_TERNARY);
        hold_cycles = 120;
        in_quiet = 1'b1;
        send_vector(5);
        send_vector(1);
        send_vector(3);
        for (int i = 0; i < 12; i++)
            send_random(1'b1);
        in_quiet = 1'b0;
        wait_drained();
    endtask

    // result checker
    initial
    begin
        int stall;
        logic [31:0] want;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sum_count++;
            if (expected_sums.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected dot_sum %0d", dot_sum);
            end
            else
            begin
                want = expected_sums.pop_front();
                if (dot_sum !== want)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("dot_sum mismatch: expected %0d actual %0d",
                                 $signed(want), dot_sum);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_valid = 1'b0;
        weight_byte = '0;
        acts_drv = '0;
        last_item = 1'b0;
        running_total = '0;
        active_mode = MODE_TERNARY;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        hold_cycles = 0;
        error_count = 0;
        mismatch_count = 0;
        request_count = 0;
        ternary_requests = 0;
        binary_requests = 0;
        sum_count = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_ternary_directed();
        test_binary_directed();
        test_mode_switch_mid_vector();
        test_random_vectors(1200);
        test_backpressure();
        wait_drained();

        $display("covered %0d requests (%0d ternary, %0d binary) and %0d dot sums",
                 request_count, ternary_requests, binary_requests, sum_count);
        $display("with mode changes, minus 128 negation, held-off output and idle gaps");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/pldp_pkg.sv
hdl/pldp_front.sv
hdl/pldp_queue.sv
hdl/pldp_back.sv
hdl/packed_low_bit_weight_dot_product.sv
test/testbench.sv
